[src/running_block_mean_error_core_defines.svh]
`ifndef RUNNING_BLOCK_MEAN_ERROR_CORE_DEFINES_SVH
`define RUNNING_BLOCK_MEAN_ERROR_CORE_DEFINES_SVH

// Checks that are switched off while the reset is held.
`define RBME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that also hold across the reset itself.
`define RBME_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/rbme_pkg.sv]
package rbme_pkg;

    localparam int MAX_BLOCKS = 4096;

    localparam int W_SAMPLE = 16;
    localparam int W_CNT    = 13;
    localparam int W_IDX    = 12;
    localparam int W_SUM    = 28;
    localparam int W_SQ     = 44;
    localparam int W_SQ_LO  = 22;
    localparam int W_SQ_HI  = W_SQ - W_SQ_LO;
    localparam int W_PP     = W_CNT + W_SQ_LO;
    localparam int W_NN     = 2 * W_CNT;
    localparam int W_NUM    = 55;
    localparam int W_DEN    = 37;
    localparam int W_Q      = 32;
    localparam int W_ROOT   = W_Q / 2;
    localparam int W_SREM   = W_ROOT + 2;
    localparam int W_ERR    = 16;
    localparam int W_ITER   = 5;

    localparam int DIV_STEPS  = W_Q;
    localparam int SQRT_STEPS = W_ROOT;

    typedef struct packed {
        logic load;
        logic acc;
        logic prep;
        logic prod2;
        logic prod3;
        logic prod4;
        logic dload;
        logic div_step;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

endpackage

[src/rbme_ctrl.sv]
`include "running_block_mean_error_core_defines.svh"

module rbme_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output rbme_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ACC   = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_PROD2 = 4'd3;
    localparam logic [3:0] S_PROD3 = 4'd4;
    localparam logic [3:0] S_PROD4 = 4'd5;
    localparam logic [3:0] S_DLOAD = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_SQRT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam logic [rbme_pkg::W_ITER-1:0] DIV_LAST  =
        rbme_pkg::W_ITER'(rbme_pkg::DIV_STEPS - 1);
    localparam logic [rbme_pkg::W_ITER-1:0] SQRT_LAST =
        rbme_pkg::W_ITER'(rbme_pkg::SQRT_STEPS - 1);

    logic [3:0]                   r_state, n_state;
    logic [rbme_pkg::W_ITER-1:0]  r_iter, n_iter;
    logic                         r_out_valid, n_out_valid;
    logic                         w_out_free;
    rbme_pkg::t_cmd               w_cmd;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = w_cmd;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_ACC;
                end
            end
            S_ACC: begin
                w_cmd.acc = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                w_cmd.prep = 1'b1;
                n_state    = S_PROD2;
            end
            S_PROD2: begin
                w_cmd.prod2 = 1'b1;
                n_state     = S_PROD3;
            end
            S_PROD3: begin
                w_cmd.prod3 = 1'b1;
                n_state     = S_PROD4;
            end
            S_PROD4: begin
                w_cmd.prod4 = 1'b1;
                n_state     = S_DLOAD;
            end
            S_DLOAD: begin
                w_cmd.dload = 1'b1;
                n_iter      = '0;
                n_state     = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                n_iter         = r_iter + 1'b1;
                if (r_iter == DIV_LAST) begin
                    n_iter  = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                w_cmd.sqrt_step = 1'b1;
                n_iter          = r_iter + 1'b1;
                if (r_iter == SQRT_LAST) begin
                    n_iter  = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    `RBME_ASSERT(a_accept_starts_item, (i_s_tvalid && o_s_tready) |=> (r_state == S_ACC),
        "accepted beat did not start the accumulation step")
    `RBME_ASSERT(a_no_result_overwrite, w_cmd.out_load |-> (!r_out_valid || i_m_tready),
        "result register loaded while it still held an untaken beat")
    `RBME_ASSERT(a_done_after_sqrt,
        (r_state == S_DONE) |-> $past(r_state == S_SQRT || r_state == S_DONE),
        "result stage reached without the square root pass")
    `RBME_ASSERT_RST(a_reset_clears_valid, !i_rst_n |=> !o_m_tvalid,
        "output valid not cleared by reset")

endmodule

[src/rbme_dp.sv]
module rbme_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rbme_pkg::t_cmd                    i_cmd,
    input  logic signed [rbme_pkg::W_SAMPLE-1:0] i_sample,
    input  logic                              i_restart,
    output logic [rbme_pkg::W_IDX-1:0]        o_block_index,
    output logic signed [rbme_pkg::W_SAMPLE-1:0] o_progressive_mean,
    output logic [rbme_pkg::W_ERR-1:0]        o_std_error,
    output logic                              o_overflow
);

    localparam int WS = rbme_pkg::W_SAMPLE;
    localparam int WC = rbme_pkg::W_CNT;

    logic signed [WS-1:0]               r_sample;
    logic                               r_restart;
    logic [WC-1:0]                      r_count;
    logic signed [rbme_pkg::W_SUM-1:0]  r_sum;
    logic [rbme_pkg::W_SQ-1:0]          r_sq;
    logic                               r_ovf;

    logic [WC-1:0]                      r_n;
    logic                               r_neg;
    logic [rbme_pkg::W_SUM-1:0]         r_mag;
    logic [rbme_pkg::W_NN-1:0]          r_nn;
    logic [rbme_pkg::W_PP-1:0]          r_plo;
    logic [rbme_pkg::W_PP-1:0]          r_phi;
    logic [rbme_pkg::W_NUM-1:0]         r_sq1;
    logic [rbme_pkg::W_DEN-1:0]         r_den;
    logic                               r_multi;
    logic [rbme_pkg::W_NUM-1:0]         r_ns2;
    logic [rbme_pkg::W_NUM-1:0]         r_num;
    logic                               r_sat;

    logic [rbme_pkg::W_DEN-1:0]         r_er;
    logic [rbme_pkg::W_Q-1:0]           r_eq;
    logic [WC-1:0]                      r_mr;
    logic [rbme_pkg::W_Q-1:0]           r_mq;
    logic [rbme_pkg::W_SREM-1:0]        r_srem;
    logic [rbme_pkg::W_ROOT-1:0]        r_root;

    logic [rbme_pkg::W_IDX-1:0]         r_o_idx;
    logic signed [WS-1:0]               r_o_mean;
    logic [rbme_pkg::W_ERR-1:0]         r_o_err;
    logic                               r_o_ovf;

    logic [WC-1:0]                      w_eff_cnt;
    logic signed [rbme_pkg::W_SUM-1:0]  w_eff_sum;
    logic [rbme_pkg::W_SQ-1:0]          w_eff_sq;
    logic                               w_full;
    logic signed [2*WS-1:0]             w_smul;
    logic [rbme_pkg::W_SUM-1:0]         w_mag;
    logic [rbme_pkg::W_SUM-1:0]         w_mdividend;
    logic [rbme_pkg::W_PP-1:0]          w_plo;
    logic [rbme_pkg::W_PP-1:0]          w_phi;
    logic [2*rbme_pkg::W_SUM-1:0]       w_sq1;
    logic [rbme_pkg::W_NN+WC-1:0]       w_den;
    logic [rbme_pkg::W_PP+rbme_pkg::W_SQ_LO-1:0] w_ns2;
    logic [rbme_pkg::W_DEN:0]           w_et;
    logic                               w_ege;
    logic [WC:0]                        w_mt;
    logic                               w_mge;
    logic [rbme_pkg::W_SREM+1:0]        w_st;
    logic [rbme_pkg::W_SREM-1:0]        w_trial;
    logic                               w_sge;
    logic signed [WS-1:0]               w_mean;
    logic [rbme_pkg::W_ERR-1:0]         w_err;

    assign w_eff_cnt = r_restart ? '0 : r_count;
    assign w_eff_sum = r_restart ? '0 : r_sum;
    assign w_eff_sq  = r_restart ? '0 : r_sq;
    assign w_full    = (w_eff_cnt >= WC'(rbme_pkg::MAX_BLOCKS));
    assign w_smul    = (2*WS)'(r_sample) * (2*WS)'(r_sample);

    assign w_mag       = r_sum[rbme_pkg::W_SUM-1] ? rbme_pkg::W_SUM'(-r_sum) : r_sum;
    assign w_mdividend = w_mag + rbme_pkg::W_SUM'(r_count >> 1);
    assign w_plo       = rbme_pkg::W_PP'(r_count) *
                         rbme_pkg::W_PP'(r_sq[rbme_pkg::W_SQ_LO-1:0]);
    assign w_phi       = rbme_pkg::W_PP'(r_n) *
                         rbme_pkg::W_PP'(r_sq[rbme_pkg::W_SQ-1:rbme_pkg::W_SQ_LO]);
    assign w_sq1       = (2*rbme_pkg::W_SUM)'(r_mag) * (2*rbme_pkg::W_SUM)'(r_mag);
    assign w_den       = (rbme_pkg::W_NN + WC)'(r_nn) * (rbme_pkg::W_NN + WC)'(r_n - 1'b1);
    assign w_ns2       = {r_phi, {rbme_pkg::W_SQ_LO{1'b0}}} +
                         (rbme_pkg::W_PP + rbme_pkg::W_SQ_LO)'(r_plo);

    assign w_et  = {r_er, r_eq[rbme_pkg::W_Q-1]};
    assign w_ege = (w_et >= {1'b0, r_den});
    assign w_mt  = {r_mr, r_mq[rbme_pkg::W_Q-1]};
    assign w_mge = (w_mt >= {1'b0, r_n});

    assign w_st    = {r_srem, r_eq[rbme_pkg::W_Q-1:rbme_pkg::W_Q-2]};
    assign w_trial = {r_root, 2'b01};
    assign w_sge   = (w_st >= (rbme_pkg::W_SREM + 2)'(w_trial));

    always_comb begin
        if (r_neg) begin
            if (r_mq > rbme_pkg::W_Q'(32768)) begin
                w_mean = WS'(-32768);
            end else begin
                w_mean = WS'(-r_mq[WS-1:0]);
            end
        end else begin
            if (r_mq > rbme_pkg::W_Q'(32767)) begin
                w_mean = WS'(32767);
            end else begin
                w_mean = r_mq[WS-1:0];
            end
        end
        if (!r_multi) begin
            w_err = '0;
        end else if (r_sat) begin
            w_err = '1;
        end else begin
            w_err = r_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
        end else if (i_cmd.acc) begin
            if (w_full) begin
                r_count <= w_eff_cnt;
                r_sum   <= w_eff_sum;
                r_sq    <= w_eff_sq;
            end else begin
                r_count <= w_eff_cnt + 1'b1;
                r_sum   <= w_eff_sum + rbme_pkg::W_SUM'(r_sample);
                r_sq    <= w_eff_sq + rbme_pkg::W_SQ'(unsigned'(w_smul));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample  <= i_sample;
            r_restart <= i_restart;
        end
        if (i_cmd.acc) begin
            r_ovf <= w_full;
        end
        if (i_cmd.prep) begin
            r_n   <= r_count;
            r_neg <= r_sum[rbme_pkg::W_SUM-1];
            r_mag <= w_mag;
            r_nn  <= rbme_pkg::W_NN'(r_count) * rbme_pkg::W_NN'(r_count);
            r_plo <= w_plo;
            r_mr  <= '0;
            r_mq  <= rbme_pkg::W_Q'(w_mdividend);
        end
        if (i_cmd.prod2) begin
            r_sq1   <= rbme_pkg::W_NUM'(w_sq1);
            r_phi   <= w_phi;
            r_den   <= rbme_pkg::W_DEN'(w_den);
            r_multi <= (r_n > WC'(1));
        end
        if (i_cmd.prod3) begin
            r_ns2 <= rbme_pkg::W_NUM'(w_ns2);
        end
        if (i_cmd.prod4) begin
            r_num <= (r_ns2 >= r_sq1) ? r_ns2 - r_sq1 : '0;
        end
        if (i_cmd.dload) begin
            r_er   <= rbme_pkg::W_DEN'(r_num[rbme_pkg::W_NUM-1:rbme_pkg::W_Q]);
            r_sat  <= (rbme_pkg::W_DEN'(r_num[rbme_pkg::W_NUM-1:rbme_pkg::W_Q]) >= r_den);
            r_eq   <= r_num[rbme_pkg::W_Q-1:0];
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.div_step) begin
            r_er <= rbme_pkg::W_DEN'(w_ege ? w_et - {1'b0, r_den} : w_et);
            r_eq <= {r_eq[rbme_pkg::W_Q-2:0], w_ege};
            r_mr <= WC'(w_mge ? w_mt - {1'b0, r_n} : w_mt);
            r_mq <= {r_mq[rbme_pkg::W_Q-2:0], w_mge};
        end
        if (i_cmd.sqrt_step) begin
            r_srem <= rbme_pkg::W_SREM'(w_sge ? w_st - (rbme_pkg::W_SREM + 2)'(w_trial)
                                              : w_st);
            r_root <= {r_root[rbme_pkg::W_ROOT-2:0], w_sge};
            r_eq   <= {r_eq[rbme_pkg::W_Q-3:0], 2'b00};
        end
        if (i_cmd.out_load) begin
            r_o_idx  <= rbme_pkg::W_IDX'(r_n - 1'b1);
            r_o_mean <= w_mean;
            r_o_err  <= w_err;
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_block_index      = r_o_idx;
    assign o_progressive_mean = r_o_mean;
    assign o_std_error        = r_o_err;
    assign o_overflow         = r_o_ovf;

endmodule

[src/running_block_mean_error_core.sv]
// Channel  Dir  Handshake              tdata (low bit up)                     tuser
// s        in   i_s_tvalid/o_s_tready  sample[15:0]                           restart
// m        out  o_m_tvalid/i_m_tready  block_index, progressive_mean,         overflow
//                                      std_error, zero fill to 48 bits
// A result is loaded into the output register as the core leaves its done state, and a
// new beat is taken in the cycle after that, so each item is finished before the next.
// Most of the work on each item is the 32-step restoring divider for the variance quotient
// and the 16-step square root; the mean divider runs alongside the variance divider.
// Reset is synchronous and active low and clears the accumulators and the handshake state.
// A stalled output holds its beat, and the core keeps working on the next item meanwhile.
module running_block_mean_error_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // sample[15:0]
    input  logic [0:0]  i_s_tuser,  // restart[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,  // block_index[11:0], progressive_mean[27:12],
                                    // std_error[43:28], zero fill[47:44]
    output logic [0:0]  o_m_tuser   // overflow[0]
);

    rbme_pkg::t_cmd                       w_cmd;
    logic [rbme_pkg::W_IDX-1:0]           w_block_index;
    logic signed [rbme_pkg::W_SAMPLE-1:0] w_progressive_mean;
    logic [rbme_pkg::W_ERR-1:0]           w_std_error;
    logic                                 w_overflow;

    rbme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    rbme_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_sample           (signed'(i_s_tdata)),
        .i_restart          (i_s_tuser[0]),
        .o_block_index      (w_block_index),
        .o_progressive_mean (w_progressive_mean),
        .o_std_error        (w_std_error),
        .o_overflow         (w_overflow)
    );

    assign o_m_tdata = {4'b0000, w_std_error, w_progressive_mean, w_block_index};
    assign o_m_tuser = w_overflow;

endmodule

[sim/running_block_mean_error_core_test.sv]
`timescale 1ns / 100ps

module running_block_mean_error_core_test;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int REPORT_LINES = 100;
    localparam int TAIL_CYCLES  = 120;

    typedef struct packed {
        logic [11:0]        block_index;
        logic signed [15:0] mean;
        logic [15:0]        std_error;
        logic               overflow;
    } t_block_stats;

    typedef enum int {
        SHAPE_ANY,
        SHAPE_FLAT,
        SHAPE_NEAR,
        SHAPE_EXTREME
    } t_sample_shape;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;   // sample[15:0]
    logic [0:0]  i_s_tuser = '0;   // restart[0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;        // block_index[11:0], progressive_mean[27:12],
                                   // std_error[43:28], zero fill[47:44]
    logic [0:0]  o_m_tuser;        // overflow[0]

    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    logic [12:0]       acc_count = '0;
    longint            acc_sum = 0;
    longint unsigned   acc_square_sum = 0;
    t_block_stats      pending_stats[$];

    running_block_mean_error_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_block_stats accumulate_block(logic signed [15:0] smp, logic clear);
        t_block_stats    r;
        longint          value;
        longint          mean;
        longint unsigned n, mag, q, num, sq1, den, err;
        r = '0;
        value = smp;
        err = 0;
        if (clear) begin
            acc_count = '0;
            acc_sum = 0;
            acc_square_sum = 0;
        end
        if (acc_count >= rbme_pkg::MAX_BLOCKS) begin
            r.overflow = 1'b1;
        end else begin
            acc_count++;
            acc_sum += value;
            acc_square_sum += value * value;
        end
        n = acc_count;
        if (n == 0) begin
            return r;
        end
        mag = (acc_sum < 0) ? -acc_sum : acc_sum;
        q = (mag + n / 2) / n;
        mean = (acc_sum < 0) ? -longint'(q) : longint'(q);
        if (mean > 32767) begin
            mean = 32767;
        end
        if (mean < -32768) begin
            mean = -32768;
        end
        if (n > 1) begin
            sq1 = mag * mag;
            num = n * acc_square_sum;
            num = (num >= sq1) ? num - sq1 : 0;
            den = n * n * (n - 1);
            err = int_sqrt(num / den);
        end
        if (err > 65535) begin
            err = 65535;
        end
        r.block_index = 12'(n - 1);
        r.mean = mean[15:0];
        r.std_error = err[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] draw_sample(t_sample_shape shape, int centre,
                                                       int spread);
        int v;
        case (shape)
            SHAPE_FLAT: begin
                v = centre;
            end
            SHAPE_NEAR: begin
                v = centre + int'($urandom_range(2 * spread)) - spread;
            end
            SHAPE_EXTREME: begin
                v = $urandom_range(1) ? 32767 : -32768;
            end
            default: begin
                v = int'($urandom_range(65535)) - 32768;
            end
        endcase
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return 16'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LINES) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_result();
        t_block_stats want;
        if (pending_stats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat, tdata %h tuser %b",
                                      o_m_tdata, o_m_tuser));
        end else begin
            want = pending_stats.pop_front();
            if (o_m_tdata[11:0] !== want.block_index) begin
                report_mismatch($sformatf("block_index %0d, expected %0d",
                                          o_m_tdata[11:0], want.block_index));
            end
            if (o_m_tdata[27:12] !== want.mean) begin
                report_mismatch($sformatf("progressive_mean %0d, expected %0d",
                                          $signed(o_m_tdata[27:12]), want.mean));
            end
            if (o_m_tdata[43:28] !== want.std_error) begin
                report_mismatch($sformatf("std_error %0d, expected %0d",
                                          o_m_tdata[43:28], want.std_error));
            end
            if (o_m_tuser[0] !== want.overflow) begin
                report_mismatch($sformatf("overflow %b, expected %b",
                                          o_m_tuser[0], want.overflow));
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            check_result();
        end
    end

    // The caller is always at a rising edge; the valid line stays high after the beat
    // is taken so that back-to-back samples need no second assignment in one step.
    task automatic send_sample(input logic signed [15:0] smp, input logic clear);
        while ($urandom_range(99) < src_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= smp;
        i_s_tuser <= clear;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        pending_stats.push_back(accumulate_block(smp, clear));
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (pending_stats.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic test_first_blocks_and_rounding();
        send_sample(-32768, 1'b1);
        send_sample(-32768, 1'b0);
        send_sample(32767, 1'b1);
        send_sample(32767, 1'b0);
        send_sample(-32768, 1'b0);
        send_sample(0, 1'b1);
        send_sample(0, 1'b0);
        send_sample(1, 1'b1);
        send_sample(2, 1'b0);
        send_sample(-1, 1'b1);
        send_sample(-2, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(32767, 1'b1);
        send_sample(-32768, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-32768, 1'b0);
        send_sample(32767, 1'b0);
        send_sample(16'sh5555, 1'b1);
        send_sample(16'shAAAA, 1'b0);
        send_sample(128, 1'b0);
        send_sample(-128, 1'b0);
        wait_for_results();
    endtask

    // Fills the accumulators to the block limit, sends samples that must be ignored,
    // then restarts from a full count.
    task automatic test_count_limit();
        send_sample(draw_sample(SHAPE_ANY, 0, 0), 1'b1);
        for (int i = 1; i < rbme_pkg::MAX_BLOCKS; i++) begin
            send_sample(draw_sample(t_sample_shape'($urandom_range(3)), 0, 20000), 1'b0);
        end
        for (int i = 0; i < 3; i++) begin
            send_sample(draw_sample(SHAPE_ANY, 0, 0), 1'b0);
        end
        send_sample(draw_sample(SHAPE_ANY, 0, 0), 1'b1);
        send_sample(draw_sample(SHAPE_ANY, 0, 0), 1'b0);
        wait_for_results();
    endtask

    task automatic test_pause_mid_run();
        send_sample(draw_sample(SHAPE_ANY, 0, 0), 1'b1);
        for (int i = 0; i < 5; i++) begin
            send_sample(draw_sample(SHAPE_NEAR, 300, 500), 1'b0);
        end
        wait_for_results();
        for (int i = 0; i < 6; i++) begin
            send_sample(draw_sample(SHAPE_NEAR, -300, 500), 1'b0);
        end
        wait_for_results();
    endtask

    task automatic test_random_runs(input int item_total);
        int            sent;
        int            run_len;
        int            centre;
        int            spread;
        logic          open_run;
        t_sample_shape shape;
        sent = 0;
        while (sent < item_total) begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 60);
            shape = t_sample_shape'($urandom_range(3));
            centre = int'($urandom_range(65535)) - 32768;
            spread = 1 << $urandom_range(14);
            // A run that carries on from the previous one without a restart.
            open_run = ($urandom_range(9) == 0);
            for (int j = 0; j < run_len; j++) begin
                send_sample(draw_sample(shape, centre, spread), (j == 0) && !open_run);
            end
            sent += run_len;
        end
        wait_for_results();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_gap_pct = 7;
        sink_stall_pct = 77;
        test_first_blocks_and_rounding();
        test_random_runs(630);
        test_pause_mid_run();

        src_gap_pct = 77;
        sink_stall_pct = 7;
        test_random_runs(630);

        src_gap_pct = 0;
        sink_stall_pct = 0;
        test_count_limit();
        test_random_runs(640);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
